[design/gqmv_pkg.sv]
// shared types and constants of the group quantized matrix-vector row block
package gqmv_pkg;

    localparam int ELEM_W     = 8;
    localparam int PROD_W     = 16;
    localparam int SCALE_W    = 24;
    localparam int SPROD_W    = 48;
    localparam int SFRAC      = 16;
    localparam int SCALE_Q_W  = 32;
    localparam int ACC_W      = 64;
    localparam int ROWLEN_W   = 13;
    localparam int ROWCNT_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_ROW_LENGTH = 2'd0;
    localparam t_cfg_idx CFG_ROW_COUNT  = 2'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SUM,
        ST_TERM,
        ST_ACC
    } t_state;

    typedef struct packed {
        logic load;
        logic grp_end;
    } t_merge_ctl;

    typedef struct packed {
        logic load_prod;
        logic load_term;
        logic acc_add;
        logic acc_clear;
    } t_scale_ctl;

endpackage

[design/gqmv_in_if.sv]
// input item channel: lane elements and group scales
interface gqmv_in_if #(
    parameter int LANES = 4
);
    import gqmv_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [ELEM_W*LANES-1:0]   act_q;
    logic [ELEM_W*LANES-1:0]   wt_q;
    logic [SCALE_W-1:0]        act_scale;
    logic [SCALE_W-1:0]        wt_scale;

    modport source (output valid, act_q, wt_q, act_scale, wt_scale, input ready);
    modport sink   (input valid, act_q, wt_q, act_scale, wt_scale, output ready);
endinterface

[design/gqmv_out_if.sv]
// result item channel: row value, index and flags
interface gqmv_out_if;
    import gqmv_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [ACC_W-1:0]  row_value;
    logic [ROWCNT_W-1:0]      row_index;
    logic                     last_row;
    logic                     saturated;

    modport source (output valid, row_value, row_index, last_row, saturated, input ready);
    modport sink   (input valid, row_value, row_index, last_row, saturated, output ready);
endinterface

[design/gqmv_cfg_if.sv]
// configuration write channel
interface gqmv_cfg_if;
    import gqmv_pkg::*;

    logic                  valid;
    logic                  ready;
    t_cfg_idx              index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[design/gqmv_lane.sv]
// one lane: registered signed product of an activation and a weight element
module gqmv_lane (
    input  logic                                i_clk,
    input  logic                                i_load,
    input  logic signed [gqmv_pkg::ELEM_W-1:0]  i_act,
    input  logic signed [gqmv_pkg::ELEM_W-1:0]  i_wt,
    output logic signed [gqmv_pkg::PROD_W-1:0]  o_prod
);
    import gqmv_pkg::*;

    logic signed [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prod <= PROD_W'(i_act) * PROD_W'(i_wt);
        end
    end

    assign o_prod = r_prod;

endmodule

[design/gqmv_merge.sv]
// merging stage: adds the lane products into the running group sum
module gqmv_merge #(
    parameter int LANES = 4,
    parameter int SUM_W = 21
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  gqmv_pkg::t_merge_ctl                i_ctl,
    input  logic [gqmv_pkg::PROD_W*LANES-1:0]   i_prods,
    output logic signed [SUM_W-1:0]             o_grp_sum
);
    import gqmv_pkg::*;

    logic signed [SUM_W-1:0] r_gsum;
    logic signed [SUM_W-1:0] r_held;
    logic signed [SUM_W-1:0] n_total;

    always_comb begin
        n_total = r_gsum;
        for (int k = 0; k < LANES; k++) begin
            n_total = n_total + SUM_W'($signed(i_prods[k*PROD_W +: PROD_W]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gsum <= '0;
        end else if (i_ctl.load) begin
            r_gsum <= i_ctl.grp_end ? '0 : n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_held <= n_total;
        end
    end

    assign o_grp_sum = r_held;

endmodule

[design/gqmv_scale.sv]
// group end path: scale product, group term and saturating row accumulator
module gqmv_scale #(
    parameter int SUM_W = 21
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  gqmv_pkg::t_scale_ctl                   i_ctl,
    input  logic [gqmv_pkg::SCALE_W-1:0]           i_act_scale,
    input  logic [gqmv_pkg::SCALE_W-1:0]           i_wt_scale,
    input  logic signed [SUM_W-1:0]                i_grp_sum,
    output logic signed [gqmv_pkg::ACC_W-1:0]      o_acc_sum,
    output logic                                   o_sat_sum
);
    import gqmv_pkg::*;

    localparam int TERM_W = SUM_W + SCALE_Q_W + 1;

    logic [SPROD_W-1:0]        r_sprod;
    logic signed [ACC_W-1:0]   r_term;
    logic signed [ACC_W-1:0]   r_acc;
    logic                      r_sat;

    logic signed [SCALE_Q_W:0] n_scale_q;
    logic signed [TERM_W-1:0]  n_term;
    logic signed [ACC_W:0]     n_wide;
    logic                      n_ovf;

    // scale product in q16.16, the top bits of a 24x24 product always fit
    assign n_scale_q = $signed({1'b0, r_sprod[SPROD_W-1:SFRAC]});
    assign n_term    = TERM_W'(i_grp_sum) * TERM_W'(n_scale_q);

    assign n_wide = {r_acc[ACC_W-1], r_acc} + {r_term[ACC_W-1], r_term};
    assign n_ovf  = n_wide[ACC_W] != n_wide[ACC_W-1];

    always_comb begin
        if (!n_ovf) begin
            o_acc_sum = n_wide[ACC_W-1:0];
        end else if (n_wide[ACC_W]) begin
            o_acc_sum = {1'b1, {(ACC_W-1){1'b0}}};
        end else begin
            o_acc_sum = {1'b0, {(ACC_W-1){1'b1}}};
        end
    end

    assign o_sat_sum = r_sat | n_ovf;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_prod) begin
            r_sprod <= SPROD_W'(i_act_scale) * SPROD_W'(i_wt_scale);
        end
        if (i_ctl.load_term) begin
            r_term <= {{(ACC_W-TERM_W){n_term[TERM_W-1]}}, n_term};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_sat <= 1'b0;
        end else if (i_ctl.acc_add) begin
            if (i_ctl.acc_clear) begin
                r_acc <= '0;
                r_sat <= 1'b0;
            end else begin
                r_acc <= o_acc_sum;
                r_sat <= o_sat_sum;
            end
        end
    end

endmodule

[design/group_quantized_matvec_row.sv]
// top level of the group quantized matrix-vector row engine
//
// usage: i_in takes one item per handshake, LANES signed 8-bit activation
// and weight pairs plus the activation and weight scales of the current
// group (unsigned q8.16, only looked at on the item that closes a group).
// o_out gives one item per finished row: the saturating q.16 row value,
// the row index, a last-row flag and a saturation flag.
// i_cfg writes row_length (index 0) and row_count (index 1); it is always
// ready and should be written between items.
// flow: i_in is ready only in the idle state, so an item is taken only once
// the last one is through; the group end item goes through the shared scale
// multiply, the term multiply and the 64-bit saturating add in turn.
// a row result is registered into o_out from the accumulate state.
// o_out is a registered output: the next items are accepted while a result
// waits; only a row end that meets a still-full output waits for it.
// reset: synchronous, clears the row, group and index state and loads
// row_length = 32 and row_count = 1; there is no clearing pass.
module group_quantized_matvec_row #(
    parameter int GROUP_SIZE     = 32,
    parameter int LANES          = 4,
    parameter int MAX_ROW_LENGTH = 4096
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    gqmv_in_if.sink    i_in,
    gqmv_cfg_if.sink   i_cfg,
    gqmv_out_if.source o_out
);
    import gqmv_pkg::*;

    localparam int SUM_W  = $clog2(GROUP_SIZE) + 16;
    localparam int POS_W  = $clog2(MAX_ROW_LENGTH + 2*GROUP_SIZE + 8192);
    localparam int IG_W   = $clog2(GROUP_SIZE + 1);

    t_state                  r_state;
    t_state                  n_state;

    logic [ROWLEN_W-1:0]     r_row_length;
    logic [ROWCNT_W-1:0]     r_row_count;

    logic [POS_W-1:0]        r_grp_start;
    logic [IG_W-1:0]         r_in_grp;
    logic                    r_grp_end;
    logic                    r_row_end;
    logic [ROWCNT_W-1:0]     r_row_cnt;

    logic                    r_out_valid;
    logic signed [ACC_W-1:0] r_out_value;
    logic [ROWCNT_W-1:0]     r_out_index;
    logic                    r_out_last;
    logic                    r_out_sat;

    logic                    accept;
    logic                    out_free;
    logic                    out_write;
    logic [IG_W-1:0]         n_in_grp;
    logic                    grp_full;
    logic [POS_W-1:0]        n_grp_start;
    logic [POS_W-1:0]        len_ext;
    logic [POS_W-1:0]        len_clamp;
    logic                    n_row_end;
    logic [ROWCNT_W-1:0]     rows_eff;
    logic [ROWCNT_W:0]       n_cnt_inc;
    logic                    n_last;

    t_merge_ctl              merge_ctl;
    t_scale_ctl              scale_ctl;
    logic [PROD_W*LANES-1:0] prods;
    logic signed [SUM_W-1:0] grp_sum;
    logic signed [ACC_W-1:0] acc_sum;
    logic                    sat_sum;

    // configuration
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_length <= ROWLEN_W'(32);
            r_row_count  <= ROWCNT_W'(1);
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_ROW_LENGTH: r_row_length <= i_cfg.data[ROWLEN_W-1:0];
                CFG_ROW_COUNT:  r_row_count  <= i_cfg.data[ROWCNT_W-1:0];
                default: ;
            endcase
        end
    end

    // position tracking inside the row
    assign accept   = i_in.valid && i_in.ready;
    assign n_in_grp = r_in_grp + IG_W'(LANES);
    assign grp_full = n_in_grp == IG_W'(GROUP_SIZE);
    assign n_grp_start = grp_full ? r_grp_start + POS_W'(GROUP_SIZE) : r_grp_start;
    assign len_ext  = POS_W'(r_row_length);

    always_comb begin
        if (len_ext < POS_W'(GROUP_SIZE)) begin
            len_clamp = POS_W'(GROUP_SIZE);
        end else if (len_ext > POS_W'(MAX_ROW_LENGTH)) begin
            len_clamp = POS_W'(MAX_ROW_LENGTH);
        end else begin
            len_clamp = len_ext;
        end
    end

    // row ends once no whole group is left below the clamped length
    assign n_row_end = (n_grp_start + POS_W'(GROUP_SIZE)) > len_clamp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grp_start <= '0;
            r_in_grp    <= '0;
            r_grp_end   <= 1'b0;
            r_row_end   <= 1'b0;
        end else if (accept) begin
            r_grp_end <= grp_full || n_row_end;
            r_row_end <= n_row_end;
            if (n_row_end) begin
                r_grp_start <= '0;
                r_in_grp    <= '0;
            end else begin
                r_grp_start <= n_grp_start;
                r_in_grp    <= grp_full ? '0 : n_in_grp;
            end
        end
    end

    // sequencer
    assign out_free = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_SUM;
                end
            end
            ST_SUM: begin
                n_state = r_grp_end ? ST_TERM : ST_IDLE;
            end
            ST_TERM: begin
                n_state = ST_ACC;
            end
            ST_ACC: begin
                if (!r_row_end || out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        i_in.ready          = 1'b0;
        merge_ctl.load      = 1'b0;
        merge_ctl.grp_end   = r_grp_end;
        scale_ctl.load_prod = accept;
        scale_ctl.load_term = 1'b0;
        scale_ctl.acc_add   = 1'b0;
        scale_ctl.acc_clear = r_row_end;
        out_write           = 1'b0;
        case (r_state)
            ST_IDLE: begin
                i_in.ready = 1'b1;
            end
            ST_SUM: begin
                merge_ctl.load = 1'b1;
            end
            ST_TERM: begin
                scale_ctl.load_term = 1'b1;
            end
            ST_ACC: begin
                scale_ctl.acc_add = !r_row_end || out_free;
                out_write         = r_row_end && out_free;
            end
            default: ;
        endcase
    end

    // lanes and merge
    for (genvar k = 0; k < LANES; k++) begin : g_lane
        gqmv_lane u_lane (
            .i_clk  (i_clk),
            .i_load (accept),
            .i_act  (i_in.act_q[k*ELEM_W +: ELEM_W]),
            .i_wt   (i_in.wt_q[k*ELEM_W +: ELEM_W]),
            .o_prod (prods[k*PROD_W +: PROD_W])
        );
    end

    gqmv_merge #(
        .LANES (LANES),
        .SUM_W (SUM_W)
    ) u_merge (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (merge_ctl),
        .i_prods   (prods),
        .o_grp_sum (grp_sum)
    );

    gqmv_scale #(
        .SUM_W (SUM_W)
    ) u_scale (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (scale_ctl),
        .i_act_scale (i_in.act_scale),
        .i_wt_scale  (i_in.wt_scale),
        .i_grp_sum   (grp_sum),
        .o_acc_sum   (acc_sum),
        .o_sat_sum   (sat_sum)
    );

    // row index and output register
    assign rows_eff  = (r_row_count == '0) ? ROWCNT_W'(1) : r_row_count;
    assign n_cnt_inc = {1'b0, r_row_cnt} + (ROWCNT_W+1)'(1);
    assign n_last    = n_cnt_inc >= {1'b0, rows_eff};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_write) begin
                r_out_valid <= 1'b1;
                r_row_cnt   <= n_last ? '0 : n_cnt_inc[ROWCNT_W-1:0];
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_write) begin
            r_out_value <= acc_sum;
            r_out_index <= r_row_cnt;
            r_out_last  <= n_last;
            r_out_sat   <= sat_sum;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.row_value = r_out_value;
    assign o_out.row_index = r_out_index;
    assign o_out.last_row  = r_out_last;
    assign o_out.saturated = r_out_sat;

`ifndef SYNTHESIS
    a_row_end_closes_grp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row_end |-> r_grp_end)
        else $error("row end without group end");

    a_in_grp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_grp < IG_W'(GROUP_SIZE))
        else $error("group element count out of range");

    a_accept_to_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == ST_SUM))
        else $error("accepted item did not reach merge stage");

    a_term_only_grp_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_TERM) |-> r_grp_end)
        else $error("term stage without group end");

    a_write_shows_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_write |=> o_out.valid)
        else $error("row result not presented");
`endif

endmodule

[verif/group_quantized_matvec_row_tb.sv]
`timescale 1ns / 1ps
// self-checking testbench for the group quantized matrix-vector row engine
module group_quantized_matvec_row_tb;
    import gqmv_pkg::*;

    localparam int GROUP_SIZE      = 32;
    localparam int LANES           = 4;
    localparam int MAX_ROW_LENGTH  = 4096;
    localparam int LONG_ROW_LENGTH = 512;
    localparam int SETTLE_CYCLES   = 12;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int STALL_LIMIT     = 4000;
    localparam int RANDOM_BEATS    = 400;
    localparam t_cfg_idx CFG_SPARE = 2'd3;

    typedef struct packed {
        logic [LANES-1:0][ELEM_W-1:0] act;
        logic [LANES-1:0][ELEM_W-1:0] wt;
        logic [SCALE_W-1:0]           act_scale;
        logic [SCALE_W-1:0]           wt_scale;
    } beat_t;

    typedef struct packed {
        logic signed [ACC_W-1:0] row_value;
        logic [ROWCNT_W-1:0]     row_index;
        logic                    last_row;
        logic                    saturated;
    } row_result_t;

    logic i_clk;
    logic i_rst_n;

    gqmv_in_if #(.LANES(LANES)) in_if ();
    gqmv_cfg_if                 cfg_if ();
    gqmv_out_if                 out_if ();

    group_quantized_matvec_row #(
        .GROUP_SIZE     (GROUP_SIZE),
        .LANES          (LANES),
        .MAX_ROW_LENGTH (MAX_ROW_LENGTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .i_cfg   (cfg_if),
        .o_out   (out_if)
    );

    // mirror of the row engine state
    logic [ROWLEN_W-1:0]     row_length_reg;
    logic [ROWCNT_W-1:0]     row_count_reg;
    int unsigned             elem_pos;
    logic signed [31:0]      group_sum;
    logic signed [ACC_W-1:0] row_acc;
    logic [ROWCNT_W-1:0]     row_ctr;
    logic                    sat_seen;

    row_result_t expected_rows[$];
    int          errors;
    int unsigned beats_in;
    int unsigned tx_gap_pct;
    int unsigned rx_stall_pct;
    bit          hold_off_req;
    int unsigned stall_left;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic bit row_dot_step(input beat_t b, output row_result_t r);
        int unsigned             len;
        int unsigned             rows;
        int unsigned             next_pos;
        int                      k;
        logic [SPROD_W-1:0]      sprod;
        logic [SCALE_Q_W-1:0]    qscale;
        logic signed [ACC_W-1:0] wide_sum;
        logic signed [ACC_W-1:0] term;
        logic signed [ACC_W:0]   total;
        len = 32'(row_length_reg);
        if (len < GROUP_SIZE) len = GROUP_SIZE;
        if (len > MAX_ROW_LENGTH) len = MAX_ROW_LENGTH;
        len = len - len % GROUP_SIZE;
        rows = (row_count_reg == '0) ? 1 : 32'(row_count_reg);
        r = '0;
        for (k = 0; k < LANES; k++) begin
            group_sum = group_sum + 32'($signed(b.act[k])) * 32'($signed(b.wt[k]));
        end
        next_pos = elem_pos + LANES;
        if (next_pos % GROUP_SIZE == 0 || next_pos >= len) begin
            sprod = SPROD_W'(b.act_scale) * SPROD_W'(b.wt_scale);
            sprod = sprod >> SFRAC;
            if (sprod > SPROD_W'(32'hFFFF_FFFF)) begin
                qscale = '1;
                sat_seen = 1'b1;
            end else begin
                qscale = sprod[SCALE_Q_W-1:0];
            end
            wide_sum = ACC_W'(group_sum);
            term = wide_sum * $signed({{(ACC_W-SCALE_Q_W){1'b0}}, qscale});
            total = (ACC_W+1)'(row_acc) + (ACC_W+1)'(term);
            if (total[ACC_W] != total[ACC_W-1]) begin
                row_acc = total[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
                sat_seen = 1'b1;
            end else begin
                row_acc = total[ACC_W-1:0];
            end
            group_sum = '0;
        end
        if (next_pos >= len) begin
            r.row_value = row_acc;
            r.row_index = row_ctr;
            r.last_row  = (32'(row_ctr) + 1 >= rows);
            r.saturated = sat_seen;
            row_ctr   = r.last_row ? '0 : row_ctr + 1'b1;
            row_acc   = '0;
            sat_seen  = 1'b0;
            group_sum = '0;
            elem_pos  = 0;
            return 1'b1;
        end
        elem_pos = next_pos;
        return 1'b0;
    endfunction

    function automatic int unsigned idle_len(input int unsigned pct);
        if ($urandom_range(99) >= pct) return 0;
        if ($urandom_range(9) == 0) return $urandom_range(40, 10);
        return $urandom_range(3, 1);
    endfunction

    function automatic logic [SCALE_W-1:0] pick_scale();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            2: return SCALE_W'($urandom_range(255));
            default: return SCALE_W'($urandom);
        endcase
    endfunction

    function automatic beat_t random_beat();
        beat_t b;
        b.act       = $urandom;
        b.wt        = $urandom;
        b.act_scale = pick_scale();
        b.wt_scale  = pick_scale();
        return b;
    endfunction

    task automatic send_beat(input beat_t b);
        row_result_t r;
        int unsigned gap;
        in_if.valid     <= 1'b1;
        in_if.act_q     <= b.act;
        in_if.wt_q      <= b.wt;
        in_if.act_scale <= b.act_scale;
        in_if.wt_scale  <= b.wt_scale;
        do @(posedge i_clk); while (!in_if.ready);
        beats_in++;
        if (row_dot_step(b, r)) expected_rows.push_back(r);
        gap = idle_len(tx_gap_pct);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data,
                             input bit more = 1'b0);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        do @(posedge i_clk); while (!cfg_if.ready);
        case (idx)
            CFG_ROW_LENGTH: row_length_reg = data[ROWLEN_W-1:0];
            CFG_ROW_COUNT:  row_count_reg = data;
            default: ;
        endcase
        if (!more) cfg_if.valid <= 1'b0;
    endtask

    task automatic wait_idle();
        in_if.valid <= 1'b0;
        while (expected_rows.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_extremes();
        logic [3:0][ELEM_W-1:0] corner = {8'h80, 8'h7F, 8'h00, 8'hFF};
        beat_t b;
        int    i;
        int    k;
        // both registers below range, plus a write to an unmapped index
        cfg_write(CFG_ROW_LENGTH, '0, 1'b1);
        cfg_write(CFG_ROW_COUNT, '0, 1'b1);
        cfg_write(CFG_SPARE, '1);
        tx_gap_pct   = 30;
        rx_stall_pct = 30;
        for (i = 0; i < GROUP_SIZE / LANES; i++) begin
            b = random_beat();
            for (k = 0; k < LANES; k++) begin
                b.act[k] = corner[(i + k) % 4];
                b.wt[k]  = corner[(i + k + i / 4) % 4];
            end
            if (i == GROUP_SIZE / LANES - 1) begin
                b.act_scale = '1;
                b.wt_scale  = '1;
            end
            send_beat(b);
        end
    endtask

    task automatic test_mid_row_change();
        wait_idle();
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
        // masked to 13 bits and clamped to the longest row
        cfg_write(CFG_ROW_LENGTH, '1, 1'b1);
        cfg_write(CFG_ROW_COUNT, 16'd3);
        repeat (GROUP_SIZE / LANES + 1) send_beat(random_beat());
        wait_idle();
        // no whole group fits below the new length: next item closes the row
        cfg_write(CFG_ROW_LENGTH, 16'd40);
        send_beat(random_beat());
        wait_idle();
        // row counter already at the new count: next row is the last
        cfg_write(CFG_ROW_COUNT, 16'd1);
        repeat (GROUP_SIZE / LANES) send_beat(random_beat());
    endtask

    task automatic test_long_row();
        beat_t b;
        wait_idle();
        cfg_write(CFG_ROW_LENGTH, 16'(LONG_ROW_LENGTH), 1'b1);
        cfg_write(CFG_ROW_COUNT, '1);
        tx_gap_pct   = 10;
        rx_stall_pct = 10;
        b.act       = {LANES{8'h80}};
        b.wt        = {LANES{8'h80}};
        b.act_scale = '1;
        b.wt_scale  = '1;
        repeat (LONG_ROW_LENGTH / LANES) send_beat(b);
    endtask

    task automatic test_backpressure();
        wait_idle();
        cfg_write(CFG_ROW_LENGTH, 16'(GROUP_SIZE), 1'b1);
        cfg_write(CFG_ROW_COUNT, 16'd4);
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
        hold_off_req = 1'b1;
        repeat (6 * GROUP_SIZE / LANES) send_beat(random_beat());
        // sender holds until every row has come out
        wait_idle();
        tx_gap_pct   = 30;
        rx_stall_pct = 30;
        repeat (2 * GROUP_SIZE / LANES) send_beat(random_beat());
    endtask

    task automatic test_random_shapes();
        int unsigned             start;
        int unsigned             n;
        logic [CFG_DATA_W-1:0]   len_data;
        logic [CFG_DATA_W-1:0]   cnt_data;
        start = beats_in;
        while (beats_in - start < RANDOM_BEATS) begin
            wait_idle();
            case ($urandom_range(5))
                0: len_data = CFG_DATA_W'($urandom_range(31));
                1: len_data = {3'($urandom), 13'($urandom_range(256, 32))};
                2: len_data = CFG_DATA_W'(GROUP_SIZE);
                default: len_data = CFG_DATA_W'($urandom_range(256, 32));
            endcase
            case ($urandom_range(5))
                0: cnt_data = '0;
                1: cnt_data = '1;
                2: cnt_data = CFG_DATA_W'($urandom);
                default: cnt_data = CFG_DATA_W'($urandom_range(6, 1));
            endcase
            cfg_write(CFG_ROW_LENGTH, len_data, 1'b1);
            cfg_write(CFG_ROW_COUNT, cnt_data);
            tx_gap_pct   = 25 * $urandom_range(2);
            rx_stall_pct = 25 * $urandom_range(2);
            n = $urandom_range(80, 16);
            repeat (n) send_beat(random_beat());
        end
    endtask

    // result side: check each row and drive ready
    initial begin
        row_result_t got;
        row_result_t want;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (out_if.valid && out_if.ready) begin
                got = {out_if.row_value, out_if.row_index, out_if.last_row, out_if.saturated};
                if (expected_rows.size() == 0) begin
                    $display("%0t: unexpected row: value %0d index %0d last %0b sat %0b",
                             $time, got.row_value, got.row_index, got.last_row, got.saturated);
                    errors++;
                end else begin
                    want = expected_rows.pop_front();
                    if (got !== want) begin
                        $display("%0t: row mismatch: expected value %0d index %0d last %0b sat %0b",
                                 $time, want.row_value, want.row_index, want.last_row,
                                 want.saturated);
                        $display("%0t:                 actual value %0d index %0d last %0b sat %0b",
                                 $time, got.row_value, got.row_index, got.last_row,
                                 got.saturated);
                        errors++;
                    end
                end
            end
            if (hold_off_req) begin
                stall_left   = HOLD_OFF_CYCLES;
                hold_off_req = 1'b0;
            end else if (stall_left == 0) begin
                stall_left = idle_len(rx_stall_pct);
            end
            if (stall_left > 0) begin
                out_if.ready <= 1'b0;
                stall_left--;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles without any accepted item
    initial begin
        int unsigned idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)
                    || (cfg_if.valid && cfg_if.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
        $display("group_quantized_matvec_row regression: fail");
        $finish;
    end

    initial begin
        i_rst_n         <= 1'b0;
        in_if.valid     <= 1'b0;
        in_if.act_q     <= '0;
        in_if.wt_q      <= '0;
        in_if.act_scale <= '0;
        in_if.wt_scale  <= '0;
        cfg_if.valid    <= 1'b0;
        cfg_if.index    <= CFG_ROW_LENGTH;
        cfg_if.data     <= '0;
        errors          = 0;
        beats_in        = 0;
        tx_gap_pct      = 0;
        rx_stall_pct    = 0;
        hold_off_req    = 1'b0;
        stall_left      = 0;
        row_length_reg  = ROWLEN_W'(32);
        row_count_reg   = ROWCNT_W'(1);
        elem_pos        = 0;
        group_sum       = '0;
        row_acc         = '0;
        row_ctr         = '0;
        sat_seen        = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_extremes();
        test_mid_row_change();
        test_long_row();
        test_backpressure();
        test_random_shapes();
        wait_idle();
        if (errors == 0) begin
            $display("group_quantized_matvec_row regression: pass");
        end else begin
            $display("group_quantized_matvec_row regression: fail");
        end
        $finish;
    end

endmodule
